### sv/fold_gram_accumulator_assert.svh
// Assertion macros for the fold Gram accumulator.
`ifndef FOLD_GRAM_ACCUMULATOR_ASSERT_SVH
`define FOLD_GRAM_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FGA_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fold_gram_accumulator: assertion failed");
`define FGA_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fold_gram_accumulator: assertion failed");
`else
`define FGA_ASSERT_IMP(label, a, b)
`define FGA_ASSERT_NXT(label, a, b)
`endif
`endif

### sv/fga_pkg.sv
package fga_pkg;

    localparam int MAX_FEATURES = 16;
    localparam int MAX_FOLDS    = 16;
    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 56;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int GRAM_AW      = 12;
    localparam int VEC_AW       = 9;
    localparam int PROD_W       = 2 * SAMPLE_W;

    localparam logic signed [SAMPLE_W-1:0] ONE_Q = SAMPLE_W'(4096);

    typedef enum logic [2:0] {
        OP_ACC    = 3'd0,
        OP_RD_GRAM = 3'd1,
        OP_RD_CROSS = 3'd2,
        OP_RD_ENERGY = 3'd3,
        OP_CLEAR  = 3'd4
    } opcode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CFG_NUM_FEATURES = 2'd0;
    localparam logic [1:0] CFG_ADD_BIAS     = 2'd1;
    localparam logic [1:0] CFG_NUM_FOLDS    = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] num_features;
        logic             add_bias;
        logic [CNT_W-1:0] num_folds;
    } cfg_t;

    typedef struct packed {
        logic                       rmw;
        logic                       vec;
        logic [GRAM_AW-1:0]         addr;
        logic signed [SAMPLE_W-1:0] mul_a;
        logic signed [SAMPLE_W-1:0] mul_b;
    } mem_req_t;

endpackage

### sv/fga_if.sv
interface fga_req_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          opcode;
    logic signed [fga_pkg::SAMPLE_W-1:0] feature_value;
    logic signed [fga_pkg::SAMPLE_W-1:0] target_value;
    logic [fga_pkg::IDX_W-1:0]           row_index;
    logic [fga_pkg::IDX_W-1:0]           col_index;
    logic [fga_pkg::IDX_W-1:0]           fold_index;

    modport source(output valid, opcode, feature_value, target_value, row_index, col_index,
                   fold_index, input ready);
    modport sink(input valid, opcode, feature_value, target_value, row_index, col_index,
                 fold_index, output ready);
endinterface

interface fga_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [fga_pkg::ACC_W-1:0] read_data;
    logic [1:0]                       status;
    logic                             line_done;

    modport source(output valid, read_data, status, line_done, input ready);
    modport sink(input valid, read_data, status, line_done, output ready);
endinterface

### sv/fold_gram_accumulator.sv
// An accumulate item adds c+2 entries for each column c it adds (gram entries plus the
// cross entry), one more for the energy update at the end of a line, and passes through
// accept, drain and result states; entries go one per cycle through the memory port.
// An in-range read passes through issue, wait and result states; one item is in work.
// After reset and after a clear item the stores are swept to zero, all 4096 addresses,
// during which no item is accepted; configuration resets to 1 feature, no bias, 10 folds.
`include "fold_gram_accumulator_assert.svh"

module fold_gram_accumulator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [fga_pkg::CNT_W-1:0] cfg_data,
    fga_req_if.sink     req,
    fga_rsp_if.source   rsp
);

    fga_pkg::cfg_t     cfg_reg;
    fga_pkg::mem_req_t mem_req;
    logic              clr_en;
    logic [fga_pkg::GRAM_AW-1:0] clr_addr;
    logic [fga_pkg::ACC_W-1:0]   rd_data;
    logic              sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_features <= fga_pkg::CNT_W'(1);
            cfg_reg.add_bias     <= 1'b0;
            cfg_reg.num_folds    <= fga_pkg::CNT_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fga_pkg::CFG_NUM_FEATURES: cfg_reg.num_features <= cfg_data;
                fga_pkg::CFG_ADD_BIAS:     cfg_reg.add_bias     <= cfg_data[0];
                fga_pkg::CFG_NUM_FOLDS:    cfg_reg.num_folds    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fga_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .req      (req),
        .rsp      (rsp),
        .mem_req  (mem_req),
        .clr_en   (clr_en),
        .clr_addr (clr_addr),
        .rd_data  (rd_data),
        .sat      (sat)
    );

    fga_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .clr_en   (clr_en),
        .clr_addr (clr_addr),
        .rd_data  (rd_data),
        .sat      (sat)
    );

    `FGA_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `FGA_ASSERT_IMP(a_range_zero, rsp.valid && rsp.status == fga_pkg::ST_RANGE, rsp.read_data == '0)
    `FGA_ASSERT_IMP(a_done_no_range, rsp.valid && rsp.line_done, rsp.status != fga_pkg::ST_RANGE)

endmodule

### sv/fga_store.sv
module fga_store
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fga_pkg::mem_req_t             req,
    input  logic                          clr_en,
    input  logic [fga_pkg::GRAM_AW-1:0]   clr_addr,
    output logic [fga_pkg::ACC_W-1:0]     rd_data,
    output logic                          sat
);

    logic [fga_pkg::ACC_W-1:0] gram_mem [2**fga_pkg::GRAM_AW];
    logic [fga_pkg::ACC_W-1:0] vec_mem  [2**fga_pkg::VEC_AW];

    logic [fga_pkg::ACC_W-1:0]        gram_q_reg;
    logic [fga_pkg::ACC_W-1:0]        vec_q_reg;
    logic signed [fga_pkg::PROD_W-1:0] prod_reg;
    logic signed [fga_pkg::PROD_W-1:0] prod_next;
    logic                             wr_pend_reg;
    logic                             wr_vec_reg;
    logic [fga_pkg::GRAM_AW-1:0]      wr_addr_reg;
    logic [fga_pkg::ACC_W:0]          sum;
    logic                             ovf;
    logic [fga_pkg::ACC_W-1:0]        sum_sat;

    assign prod_next = req.mul_a * req.mul_b;

    always_ff @(posedge clk)
    begin
        gram_q_reg  <= gram_mem[req.addr];
        vec_q_reg   <= vec_mem[req.addr[fga_pkg::VEC_AW-1:0]];
        prod_reg    <= prod_next;
        wr_vec_reg  <= req.vec;
        wr_addr_reg <= req.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= req.rmw;
        end
    end

    assign rd_data = wr_vec_reg ? vec_q_reg : gram_q_reg;

    always_comb
    begin
        sum = {rd_data[fga_pkg::ACC_W-1], rd_data}
            + {{(fga_pkg::ACC_W + 1 - fga_pkg::PROD_W){prod_reg[fga_pkg::PROD_W-1]}}, prod_reg};
        ovf = sum[fga_pkg::ACC_W] != sum[fga_pkg::ACC_W-1];
        if (ovf)
        begin
            sum_sat = sum[fga_pkg::ACC_W] ? {1'b1, {(fga_pkg::ACC_W-1){1'b0}}}
                                          : {1'b0, {(fga_pkg::ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[fga_pkg::ACC_W-1:0];
        end
    end

    assign sat = wr_pend_reg && ovf;

    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            gram_mem[clr_addr] <= '0;
            vec_mem[clr_addr[fga_pkg::VEC_AW-1:0]] <= '0;
        end
        else if (wr_pend_reg)
        begin
            if (wr_vec_reg)
            begin
                vec_mem[wr_addr_reg[fga_pkg::VEC_AW-1:0]] <= sum_sat;
            end
            else
            begin
                gram_mem[wr_addr_reg] <= sum_sat;
            end
        end
    end

endmodule

### sv/fga_seq.sv
module fga_seq
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fga_pkg::cfg_t                   cfg,
    fga_req_if.sink                         req,
    fga_rsp_if.source                       rsp,
    output fga_pkg::mem_req_t               mem_req,
    output logic                            clr_en,
    output logic [fga_pkg::GRAM_AW-1:0]     clr_addr,
    input  logic [fga_pkg::ACC_W-1:0]       rd_data,
    input  logic                            sat
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_GRAM   = 9'b000000010,
        S_CROSS  = 9'b000000100,
        S_ENERGY = 9'b000001000,
        S_DRAIN  = 9'b000010000,
        S_RDISS  = 9'b000100000,
        S_RDWAIT = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    localparam int IW = fga_pkg::IDX_W;
    localparam int CW = fga_pkg::CNT_W;
    localparam int SW = fga_pkg::SAMPLE_W;

    state_t state_reg, state_next;

    logic [CW-1:0]        pos_reg;
    logic [IW-1:0]        fold_reg;
    logic [IW-1:0]        col_reg;
    logic [IW-1:0]        xcol_reg;
    logic [IW-1:0]        j_reg;
    logic signed [SW-1:0] v_reg;
    logic signed [SW-1:0] x_reg;
    logic signed [SW-1:0] t_reg;
    logic                 do_x_reg;
    logic                 line_end_reg;
    logic                 rd_vec_reg;
    logic [fga_pkg::GRAM_AW-1:0] addr_reg;
    logic                 sat_reg;
    logic [fga_pkg::ACC_W-1:0] res_data_reg;
    logic [1:0]           res_status_reg;
    logic                 res_done_reg;
    logic [fga_pkg::GRAM_AW-1:0] clr_cnt_reg;
    logic                 clr_op_reg;
    logic                 out_valid_reg;
    logic [fga_pkg::ACC_W-1:0] out_data_reg;
    logic [1:0]           out_status_reg;
    logic                 out_done_reg;
    logic signed [SW-1:0] lb_reg [fga_pkg::MAX_FEATURES];

    logic [CW-1:0]        nf;
    logic [CW-1:0]        nk;
    logic                 bias_now;
    logic [CW-1:0]        p1;
    logic [CW-1:0]        p2;
    logic                 do_x;
    logic                 line_end;
    logic                 bad;
    logic [IW-1:0]        fold_next;
    logic                 out_free;
    logic [CW-1:0]        fold_inc;

    always_comb
    begin
        if (cfg.num_features == '0)
        begin
            nf = CW'(1);
        end
        else if (cfg.num_features > CW'(fga_pkg::MAX_FEATURES))
        begin
            nf = CW'(fga_pkg::MAX_FEATURES);
        end
        else
        begin
            nf = cfg.num_features;
        end
        if (cfg.num_folds == '0)
        begin
            nk = CW'(1);
        end
        else if (cfg.num_folds > CW'(fga_pkg::MAX_FOLDS))
        begin
            nk = CW'(fga_pkg::MAX_FOLDS);
        end
        else
        begin
            nk = cfg.num_folds;
        end
    end

    assign bias_now = (pos_reg == '0) && cfg.add_bias;
    assign p1       = bias_now ? CW'(1) : pos_reg;
    assign do_x     = p1 < nf;
    assign p2       = do_x ? p1 + CW'(1) : p1;
    assign line_end = p2 >= nf;
    assign fold_inc = {1'b0, fold_reg} + CW'(1);
    assign fold_next = (fold_inc >= nk) ? '0 : fold_inc[IW-1:0];
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        bad = {1'b0, req.fold_index} >= nk;
        if ((req.opcode == fga_pkg::OP_RD_GRAM || req.opcode == fga_pkg::OP_RD_CROSS)
            && {1'b0, req.row_index} >= nf)
        begin
            bad = 1'b1;
        end
        if (req.opcode == fga_pkg::OP_RD_GRAM && {1'b0, req.col_index} >= nf)
        begin
            bad = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.opcode)
                        fga_pkg::OP_ACC:
                        begin
                            state_next = (bias_now || do_x) ? S_GRAM : S_ENERGY;
                        end
                        fga_pkg::OP_RD_GRAM, fga_pkg::OP_RD_CROSS, fga_pkg::OP_RD_ENERGY:
                        begin
                            state_next = bad ? S_DONE : S_RDISS;
                        end
                        fga_pkg::OP_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_GRAM:
            begin
                if (j_reg == col_reg)
                begin
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                priority if (do_x_reg)
                begin
                    state_next = S_GRAM;
                end
                else if (line_end_reg)
                begin
                    state_next = S_ENERGY;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_ENERGY: state_next = S_DRAIN;
            S_DRAIN:  state_next = S_DONE;
            S_RDISS:  state_next = S_RDWAIT;
            S_RDWAIT: state_next = S_DONE;
            S_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_req.rmw   = 1'b0;
        mem_req.vec   = rd_vec_reg;
        mem_req.addr  = addr_reg;
        mem_req.mul_a = v_reg;
        mem_req.mul_b = t_reg;
        if (state_reg == S_GRAM)
        begin
            mem_req.rmw   = 1'b1;
            mem_req.vec   = 1'b0;
            mem_req.addr  = {fold_reg, col_reg, j_reg};
            mem_req.mul_b = (j_reg == col_reg) ? v_reg : lb_reg[j_reg];
        end
        else if (state_reg == S_CROSS)
        begin
            mem_req.rmw  = 1'b1;
            mem_req.vec  = 1'b1;
            mem_req.addr = {3'b000, 1'b0, fold_reg, col_reg};
        end
        else if (state_reg == S_ENERGY)
        begin
            mem_req.rmw   = 1'b1;
            mem_req.vec   = 1'b1;
            mem_req.addr  = {3'b000, 1'b1, fold_reg, {IW{1'b0}}};
            mem_req.mul_a = t_reg;
        end
    end

    assign clr_en   = state_reg == S_CLEAR;
    assign clr_addr = clr_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CROSS)
        begin
            lb_reg[col_reg] <= v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pos_reg        <= '0;
            fold_reg       <= '0;
            clr_cnt_reg    <= '0;
            clr_op_reg     <= 1'b0;
            do_x_reg       <= 1'b0;
            line_end_reg   <= 1'b0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && req.valid)
            begin
                sat_reg <= 1'b0;
            end
            else if (sat)
            begin
                sat_reg <= 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        res_data_reg   <= '0;
                        res_done_reg   <= (req.opcode == fga_pkg::OP_ACC) && line_end;
                        j_reg          <= '0;
                        t_reg          <= req.target_value;
                        x_reg          <= req.feature_value;
                        rd_vec_reg     <= req.opcode != fga_pkg::OP_RD_GRAM;
                        unique case (req.opcode)
                            fga_pkg::OP_ACC:
                            begin
                                res_status_reg <= fga_pkg::ST_OK;
                                do_x_reg     <= bias_now && do_x;
                                xcol_reg     <= p1[IW-1:0];
                                line_end_reg <= line_end;
                                pos_reg      <= line_end ? '0 : p2;
                                col_reg      <= bias_now ? '0 : p1[IW-1:0];
                                v_reg        <= bias_now ? fga_pkg::ONE_Q : req.feature_value;
                            end
                            fga_pkg::OP_RD_GRAM:
                            begin
                                res_status_reg <= bad ? fga_pkg::ST_RANGE : fga_pkg::ST_OK;
                                addr_reg <= (req.row_index >= req.col_index)
                                    ? {req.fold_index, req.row_index, req.col_index}
                                    : {req.fold_index, req.col_index, req.row_index};
                            end
                            fga_pkg::OP_RD_CROSS:
                            begin
                                res_status_reg <= bad ? fga_pkg::ST_RANGE : fga_pkg::ST_OK;
                                addr_reg <= {3'b000, 1'b0, req.fold_index, req.row_index};
                            end
                            fga_pkg::OP_RD_ENERGY:
                            begin
                                res_status_reg <= bad ? fga_pkg::ST_RANGE : fga_pkg::ST_OK;
                                addr_reg <= {3'b000, 1'b1, req.fold_index, {IW{1'b0}}};
                            end
                            fga_pkg::OP_CLEAR:
                            begin
                                res_status_reg <= fga_pkg::ST_OK;
                                clr_cnt_reg <= '0;
                                clr_op_reg  <= 1'b1;
                            end
                            default:
                            begin
                                res_status_reg <= fga_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_GRAM:
                begin
                    j_reg <= (j_reg == col_reg) ? '0 : j_reg + IW'(1);
                end
                S_CROSS:
                begin
                    if (do_x_reg)
                    begin
                        do_x_reg <= 1'b0;
                        col_reg  <= xcol_reg;
                        v_reg    <= x_reg;
                    end
                end
                S_ENERGY:
                begin
                    fold_reg <= fold_next;
                end
                S_RDWAIT:
                begin
                    res_data_reg <= rd_data;
                end
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + fga_pkg::GRAM_AW'(1);
                    pos_reg     <= '0;
                    fold_reg    <= '0;
                    if (clr_cnt_reg == '1)
                    begin
                        clr_op_reg <= 1'b0;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg   <= res_data_reg;
                        out_status_reg <= sat_reg ? fga_pkg::ST_SAT : res_status_reg;
                        out_done_reg   <= res_done_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign req.ready     = state_reg == S_IDLE;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.line_done = out_done_reg;

endmodule
